/* sv/taps_pkg.sv */
// Shared widths, codes, command and status types and the arctangent table of the solver.
`default_nettype none
package taps_pkg;

   localparam int RANGE_W     = 24;
   localparam int X_W         = 25;
   localparam int ANG_W       = 16;
   localparam int SQ_W        = 48;
   localparam int MUL_W       = 26;
   localparam int PROD_W      = 52;
   localparam int NUM_W       = 51;
   localparam int DIVN_W      = 50;
   localparam int DIV_W       = 25;
   localparam int ROOT_W      = 26;
   localparam int SQRT_REM_W  = 28;
   localparam int CORD_W      = 56;
   localparam int Z_W         = 34;
   localparam int TAB_FRAC    = 24;
   localparam int TAB_IDX_W   = 5;
   localparam int TAB_W       = 30;
   localparam int CNT_W       = 5;

   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int CORDIC_STEPS_DEF    = 16;

   localparam logic [RANGE_W-1:0] BASELINE_RESET = 24'd19661;
   localparam logic               ANCHOR_RIGHT   = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_AA, ST_MUL_BB, ST_MUL_CC, ST_MUL_CA, ST_MUL_P1, ST_MUL_P2,
      ST_SQRT_P1, ST_SQRT_P2, ST_MUL_HY, ST_DIV, ST_MUL_QQ, ST_SQRT_H,
      ST_CORD_T, ST_CORD_L, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_IDLE, OP_MUL_AA, OP_MUL_BB, OP_MUL_CC, OP_MUL_CA, OP_MUL_P1, OP_MUL_P2,
      OP_SQRT_P1, OP_SQRT_P2, OP_MUL_HY, OP_DIV, OP_MUL_QQ, OP_SQRT_H,
      OP_CORD_T, OP_CORD_L, OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   launch;
      logic   load_left;
      logic   load_right;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic in_zero;
      logic sqrt_done;
      logic div_done;
      logic cordic_done;
   } status_type;

   // Arctangent of 2^-i in degrees with 24 fraction bits.
   function automatic logic [TAB_W-1:0] atan_q24(input logic [TAB_IDX_W-1:0] idx);
      logic [TAB_W-1:0] v;
      unique case (idx)
         5'd0:  v = 30'd754974720;
         5'd1:  v = 30'd445687602;
         5'd2:  v = 30'd235489088;
         5'd3:  v = 30'd119537938;
         5'd4:  v = 30'd60000934;
         5'd5:  v = 30'd30029717;
         5'd6:  v = 30'd15018523;
         5'd7:  v = 30'd7509720;
         5'd8:  v = 30'd3754917;
         5'd9:  v = 30'd1877466;
         5'd10: v = 30'd938734;
         5'd11: v = 30'd469367;
         5'd12: v = 30'd234684;
         5'd13: v = 30'd117342;
         5'd14: v = 30'd58671;
         5'd15: v = 30'd29335;
         5'd16: v = 30'd14668;
         5'd17: v = 30'd7334;
         5'd18: v = 30'd3667;
         5'd19: v = 30'd1833;
         5'd20: v = 30'd917;
         5'd21: v = 30'd458;
         5'd22: v = 30'd229;
         5'd23: v = 30'd115;
         5'd24: v = 30'd57;
         5'd25: v = 30'd29;
         5'd26: v = 30'd14;
         5'd27: v = 30'd7;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         5'd31: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* sv/taps_sqrt.sv */
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module taps_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [taps_pkg::PROD_W-1:0]  operand,
   output logic [taps_pkg::ROOT_W-1:0]  root,
   output logic                         done
);
   import taps_pkg::*;

   logic [PROD_W-1:0]     val_ff, val_in;
   logic [SQRT_REM_W-1:0] rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQRT_REM_W-1:0] rem_shift, trial;
   logic                  ge;

   always_comb begin
      rem_shift = {rem_ff[SQRT_REM_W-3:0], val_ff[PROD_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      ge        = rem_shift >= trial;
      val_in    = val_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         val_in  = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         val_in  = {val_ff[PROD_W-3:0], 2'b00};
         rem_in  = ge ? rem_shift - trial : rem_shift;
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule
`default_nettype wire

/* sv/taps_cordic.sv */
// Iterative CORDIC vectoring unit that returns the angle of a vector in degrees.
`default_nettype none
module taps_cordic #(
   parameter int CORDIC_STEPS = taps_pkg::CORDIC_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [taps_pkg::NUM_W-1:0]  x0,
   input  logic        [taps_pkg::PROD_W-1:0] y0,
   output logic signed [taps_pkg::Z_W-1:0]    angle,
   output logic                               done
);
   import taps_pkg::*;

   localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic signed [Z_W-1:0] QUARTER = Z_W'(90 * (1 << TAB_FRAC));

   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys, x0e, y0e;
   logic signed [Z_W-1:0]    z_ff, z_in, step_angle;
   logic [IW-1:0]            cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   always_comb begin
      x0e        = {{(CORD_W - NUM_W){x0[NUM_W-1]}}, x0};
      y0e        = $signed({{(CORD_W - PROD_W){1'b0}}, y0});
      xs         = x_ff >>> cnt_ff;
      ys         = y_ff >>> cnt_ff;
      step_angle = $signed({{(Z_W - TAB_W){1'b0}}, atan_q24(TAB_IDX_W'(cnt_ff))});
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         if (x0e < 0) begin
            x_in = y0e;
            y_in = -x0e;
            z_in = QUARTER;
         end else begin
            x_in = x0e;
            y_in = y0e;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (!y_ff[CORD_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + step_angle;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - step_angle;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == IW'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign angle = z_ff;
   assign done  = done_ff;

endmodule
`default_nettype wire

/* sv/taps_datapath.sv */
// Datapath of the solver: range store, shared multiplier, divider, root and CORDIC units.
`default_nettype none
module taps_datapath #(
   parameter int ANGLE_FRAC_BITS = taps_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = taps_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  taps_pkg::cmd_type                   cmd,
   output taps_pkg::status_type                status,
   input  logic        [taps_pkg::RANGE_W-1:0] req_distance,
   input  logic                                csr_write_enable,
   input  logic        [taps_pkg::RANGE_W-1:0] csr_write_data,
   output logic signed [taps_pkg::X_W-1:0]     rsp_x_position,
   output logic        [taps_pkg::RANGE_W-1:0] rsp_y_position,
   output logic        [taps_pkg::ANG_W-1:0]   rsp_angle_at_target,
   output logic        [taps_pkg::ANG_W-1:0]   rsp_angle_at_left,
   output logic        [taps_pkg::ANG_W-1:0]   rsp_angle_at_right,
   output logic                                rsp_triangle_valid,
   output logic                                rsp_position_valid
);
   import taps_pkg::*;

   localparam int AW = ANGLE_FRAC_BITS + 8;
   localparam int SH = TAB_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [Z_W-1:0] ANG_TOP = Z_W'(longint'(180) <<< TAB_FRAC);
   localparam logic [Z_W-1:0] ANG_RND = Z_W'(1) << (SH - 1);
   localparam logic [AW-1:0] ANG_FULL = AW'(180) << ANGLE_FRAC_BITS;

   logic [RANGE_W-1:0] a_ff, b_ff, c_ff;
   logic [SQ_W-1:0]    aa_ff, bb_ff, cc_ff, ca_ff;
   logic [PROD_W-1:0]  p1_ff, p2_ff, hy_ff, qq_ff;
   logic [ROOT_W-1:0]  r1_ff, r2_ff, s_ff;
   logic signed [Z_W-1:0] zt_ff, zl_ff;

   logic [MUL_W-1:0]   mul_a, mul_b, s1, s2, s3, s4;
   logic [PROD_W-1:0]  mul_p;
   logic [RANGE_W:0]   sum_ab, sum_ac, sum_bc;
   logic               tri_ok, pos_ok;
   logic signed [NUM_W-1:0] cos_t, cos_l;
   logic [NUM_W-1:0]   mag_w;
   logic [DIVN_W-1:0]  div_n;
   logic [DIV_W-1:0]   div_d;
   logic [SQ_W-1:0]    hsq;

   logic [DIV_W-1:0]   div_rem_ff, div_rem_in, div_low_ff, div_low_in, div_q_ff, div_q_in;
   logic [CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic               div_busy_ff, div_busy_in, div_done_ff, div_done_in;
   logic [DIV_W:0]     div_t, div_diff;
   logic               div_ge;

   logic               sqrt_start, sqrt_done, cord_start, cord_done;
   logic [PROD_W-1:0]  sqrt_operand;
   logic [ROOT_W-1:0]  sqrt_root;
   logic signed [NUM_W-1:0] cord_x0;
   logic signed [Z_W-1:0]   cord_angle;

   logic [AW-1:0]      ang_t, ang_l, ang_r;
   logic signed [AW+1:0] ang_diff;
   logic [AW+ANG_W-1:0] ext_t, ext_l, ext_r;
   logic [ROOT_W-1:0]  y_round;
   logic [X_W-1:0]     x_val;

   function automatic logic [AW-1:0] to_angle(input logic signed [Z_W-1:0] z);
      logic signed [Z_W-1:0] zc;
      logic [Z_W-1:0]        sum;
      zc = z;
      if (z < 0) begin
         zc = '0;
      end else if (z > ANG_TOP) begin
         zc = ANG_TOP;
      end
      sum = Z_W'(zc) + ANG_RND;
      return sum[SH +: AW];
   endfunction

   always_comb begin
      sum_ab = {1'b0, a_ff} + {1'b0, b_ff};
      sum_ac = {1'b0, a_ff} + {1'b0, c_ff};
      sum_bc = {1'b0, b_ff} + {1'b0, c_ff};
      tri_ok = (sum_ab > {1'b0, c_ff}) && (sum_ac > {1'b0, b_ff}) && (sum_bc > {1'b0, a_ff});
      s1 = MUL_W'(a_ff) + MUL_W'(b_ff) + MUL_W'(c_ff);
      s2 = MUL_W'(a_ff) + MUL_W'(b_ff) - MUL_W'(c_ff);
      s3 = MUL_W'(a_ff) - MUL_W'(b_ff) + MUL_W'(c_ff);
      s4 = MUL_W'(b_ff) + MUL_W'(c_ff) - MUL_W'(a_ff);
      cos_t = $signed(NUM_W'(aa_ff)) + $signed(NUM_W'(bb_ff)) - $signed(NUM_W'(cc_ff));
      cos_l = $signed(NUM_W'(aa_ff)) + $signed(NUM_W'(cc_ff)) - $signed(NUM_W'(bb_ff));
      mag_w = cos_l[NUM_W-1] ? NUM_W'(-cos_l) : NUM_W'(cos_l);
      div_n = mag_w[DIVN_W-1:0] + DIVN_W'(c_ff);
      div_d = {c_ff, 1'b0};
      pos_ok = (c_ff != '0) && (mag_w[DIVN_W-1:0] <= DIVN_W'({ca_ff, 1'b0}));
      hsq = (div_q_ff <= {1'b0, a_ff}) ? aa_ff - qq_ff[SQ_W-1:0] : '0;
   end

   always_comb begin
      unique case (cmd.op)
         OP_MUL_AA: begin mul_a = MUL_W'(a_ff);     mul_b = MUL_W'(a_ff);     end
         OP_MUL_BB: begin mul_a = MUL_W'(b_ff);     mul_b = MUL_W'(b_ff);     end
         OP_MUL_CC: begin mul_a = MUL_W'(c_ff);     mul_b = MUL_W'(c_ff);     end
         OP_MUL_CA: begin mul_a = MUL_W'(c_ff);     mul_b = MUL_W'(a_ff);     end
         OP_MUL_P1: begin mul_a = s1;               mul_b = s2;               end
         OP_MUL_P2: begin mul_a = s3;               mul_b = s4;               end
         OP_MUL_HY: begin mul_a = r1_ff;            mul_b = r2_ff;            end
         OP_MUL_QQ: begin mul_a = MUL_W'(div_q_ff); mul_b = MUL_W'(div_q_ff); end
         default:   begin mul_a = '0;               mul_b = '0;               end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_MUL_AA: aa_ff <= mul_p[SQ_W-1:0];
         OP_MUL_BB: bb_ff <= mul_p[SQ_W-1:0];
         OP_MUL_CC: cc_ff <= mul_p[SQ_W-1:0];
         OP_MUL_CA: ca_ff <= mul_p[SQ_W-1:0];
         OP_MUL_P1: p1_ff <= mul_p;
         OP_MUL_P2: p2_ff <= mul_p;
         OP_MUL_HY: hy_ff <= mul_p;
         OP_MUL_QQ: qq_ff <= mul_p;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= BASELINE_RESET;
      end else if (csr_write_enable) begin
         c_ff <= csr_write_data;
      end
      if (cmd.load_left) begin
         a_ff <= req_distance;
      end
      if (cmd.load_right) begin
         b_ff <= req_distance;
      end
   end

   // Restoring division, one quotient bit per cycle; the quotient is not bounded by the left range.
   always_comb begin
      div_t       = {div_rem_ff, div_low_ff[DIV_W-1]};
      div_diff    = div_t - {1'b0, div_d};
      div_ge      = div_t >= {1'b0, div_d};
      div_rem_in  = div_rem_ff;
      div_low_in  = div_low_ff;
      div_q_in    = div_q_ff;
      div_cnt_in  = div_cnt_ff;
      div_busy_in = div_busy_ff;
      div_done_in = 1'b0;
      if (cmd.launch && (cmd.op == OP_DIV)) begin
         div_rem_in  = div_n[DIVN_W-1 -: DIV_W];
         div_low_in  = div_n[DIV_W-1:0];
         div_q_in    = '0;
         div_cnt_in  = '0;
         div_busy_in = 1'b1;
      end else if (div_busy_ff) begin
         div_rem_in = div_ge ? div_diff[DIV_W-1:0] : div_t[DIV_W-1:0];
         div_low_in = {div_low_ff[DIV_W-2:0], 1'b0};
         div_q_in   = {div_q_ff[DIV_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff + 1'b1;
         if (div_cnt_ff == CNT_W'(DIV_W - 1)) begin
            div_busy_in = 1'b0;
            div_done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      div_rem_ff <= div_rem_in;
      div_low_ff <= div_low_in;
      div_q_ff   <= div_q_in;
      if (reset) begin
         div_cnt_ff  <= '0;
         div_busy_ff <= 1'b0;
         div_done_ff <= 1'b0;
      end else begin
         div_cnt_ff  <= div_cnt_in;
         div_busy_ff <= div_busy_in;
         div_done_ff <= div_done_in;
      end
   end

   always_comb begin
      sqrt_start = cmd.launch &&
                   ((cmd.op == OP_SQRT_P1) || (cmd.op == OP_SQRT_P2) || (cmd.op == OP_SQRT_H));
      unique case (cmd.op)
         OP_SQRT_P1: sqrt_operand = p1_ff;
         OP_SQRT_P2: sqrt_operand = p2_ff;
         default:    sqrt_operand = {2'b00, hsq, 2'b00};
      endcase
      cord_start = cmd.launch && ((cmd.op == OP_CORD_T) || (cmd.op == OP_CORD_L));
      cord_x0    = (cmd.op == OP_CORD_T) ? cos_t : cos_l;
   end

   taps_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sqrt_operand),
      .root    (sqrt_root),
      .done    (sqrt_done)
   );

   taps_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .x0    (cord_x0),
      .y0    (hy_ff),
      .angle (cord_angle),
      .done  (cord_done)
   );

   always_ff @(posedge clock) begin
      if (sqrt_done) begin
         unique case (cmd.op)
            OP_SQRT_P1: r1_ff <= sqrt_root;
            OP_SQRT_P2: r2_ff <= sqrt_root;
            OP_SQRT_H:  s_ff  <= sqrt_root;
            default: begin
            end
         endcase
      end
      if (cord_done) begin
         if (cmd.op == OP_CORD_T) begin
            zt_ff <= cord_angle;
         end else begin
            zl_ff <= cord_angle;
         end
      end
   end

   always_comb begin
      ang_t    = to_angle(zt_ff);
      ang_l    = to_angle(zl_ff);
      ang_diff = $signed({2'b00, ANG_FULL}) - $signed({2'b00, ang_t}) - $signed({2'b00, ang_l});
      ang_r    = ang_diff[AW+1] ? '0 : ang_diff[AW-1:0];
      ext_t    = {{ANG_W{1'b0}}, ang_t};
      ext_l    = {{ANG_W{1'b0}}, ang_l};
      ext_r    = {{ANG_W{1'b0}}, ang_r};
      y_round  = s_ff + 1'b1;
      x_val    = cos_l[NUM_W-1] ? X_W'(-div_q_ff) : X_W'(div_q_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_triangle_valid  <= tri_ok;
         rsp_position_valid  <= pos_ok;
         rsp_angle_at_target <= tri_ok ? ext_t[ANG_W-1:0] : '0;
         rsp_angle_at_left   <= tri_ok ? ext_l[ANG_W-1:0] : '0;
         rsp_angle_at_right  <= tri_ok ? ext_r[ANG_W-1:0] : '0;
         rsp_x_position      <= pos_ok ? $signed(x_val) : '0;
         rsp_y_position      <= pos_ok ? y_round[RANGE_W:1] : '0;
      end
   end

   always_comb begin
      status.in_zero     = req_distance == '0;
      status.sqrt_done   = sqrt_done;
      status.div_done    = div_done_ff;
      status.cordic_done = cord_done;
   end

endmodule
`default_nettype wire

/* sv/taps_ctrl.sv */
// Controller state machine: range bookkeeping, solve sequencing and output handshake.
`default_nettype none
module taps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output taps_pkg::cmd_type    cmd,
   input  taps_pkg::status_type status
);
   import taps_pkg::*;

   state_type state_ff, state_in;
   logic      launched_ff, launched_in;
   logic      left_fresh_ff, left_fresh_in;
   logic      right_fresh_ff, right_fresh_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, take_word, unit_state, unit_done, out_free;

   always_comb begin
      req_stall = state_ff != ST_IDLE;
      accept    = req_valid && !req_stall;
      take_word = accept && !status.in_zero;
      out_free  = !rsp_valid_ff || !rsp_stall;
      unique case (state_ff)
         ST_SQRT_P1, ST_SQRT_P2, ST_SQRT_H: begin
            unit_state = 1'b1;
            unit_done  = status.sqrt_done;
         end
         ST_DIV: begin
            unit_state = 1'b1;
            unit_done  = status.div_done;
         end
         ST_CORD_T, ST_CORD_L: begin
            unit_state = 1'b1;
            unit_done  = status.cordic_done;
         end
         default: begin
            unit_state = 1'b0;
            unit_done  = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      launched_in    = launched_ff;
      left_fresh_in  = left_fresh_ff;
      right_fresh_in = right_fresh_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (unit_state) begin
         if (!launched_ff) begin
            launched_in = 1'b1;
         end else if (unit_done) begin
            launched_in = 1'b0;
         end
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (take_word) begin
               if ((req_type == ANCHOR_RIGHT) ? left_fresh_ff : right_fresh_ff) begin
                  left_fresh_in  = 1'b0;
                  right_fresh_in = 1'b0;
                  state_in       = ST_MUL_AA;
               end else if (req_type == ANCHOR_RIGHT) begin
                  right_fresh_in = 1'b1;
               end else begin
                  left_fresh_in = 1'b1;
               end
            end
         end
         ST_MUL_AA:  state_in = ST_MUL_BB;
         ST_MUL_BB:  state_in = ST_MUL_CC;
         ST_MUL_CC:  state_in = ST_MUL_CA;
         ST_MUL_CA:  state_in = ST_MUL_P1;
         ST_MUL_P1:  state_in = ST_MUL_P2;
         ST_MUL_P2:  state_in = ST_SQRT_P1;
         ST_SQRT_P1: if (launched_ff && unit_done) state_in = ST_SQRT_P2;
         ST_SQRT_P2: if (launched_ff && unit_done) state_in = ST_MUL_HY;
         ST_MUL_HY:  state_in = ST_DIV;
         ST_DIV:     if (launched_ff && unit_done) state_in = ST_MUL_QQ;
         ST_MUL_QQ:  state_in = ST_SQRT_H;
         ST_SQRT_H:  if (launched_ff && unit_done) state_in = ST_CORD_T;
         ST_CORD_T:  if (launched_ff && unit_done) state_in = ST_CORD_L;
         ST_CORD_L:  if (launched_ff && unit_done) state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_IDLE:    cmd.op = OP_IDLE;
         ST_MUL_AA:  cmd.op = OP_MUL_AA;
         ST_MUL_BB:  cmd.op = OP_MUL_BB;
         ST_MUL_CC:  cmd.op = OP_MUL_CC;
         ST_MUL_CA:  cmd.op = OP_MUL_CA;
         ST_MUL_P1:  cmd.op = OP_MUL_P1;
         ST_MUL_P2:  cmd.op = OP_MUL_P2;
         ST_SQRT_P1: cmd.op = OP_SQRT_P1;
         ST_SQRT_P2: cmd.op = OP_SQRT_P2;
         ST_MUL_HY:  cmd.op = OP_MUL_HY;
         ST_DIV:     cmd.op = OP_DIV;
         ST_MUL_QQ:  cmd.op = OP_MUL_QQ;
         ST_SQRT_H:  cmd.op = OP_SQRT_H;
         ST_CORD_T:  cmd.op = OP_CORD_T;
         ST_CORD_L:  cmd.op = OP_CORD_L;
         ST_OUT:     cmd.op = OP_OUT;
      endcase
      cmd.launch     = unit_state && !launched_ff;
      cmd.load_left  = take_word && (req_type != ANCHOR_RIGHT);
      cmd.load_right = take_word && (req_type == ANCHOR_RIGHT);
      cmd.out_load   = (state_ff == ST_OUT) && out_free;
      rsp_valid      = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         launched_ff    <= 1'b0;
         left_fresh_ff  <= 1'b0;
         right_fresh_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         launched_ff    <= launched_in;
         left_fresh_ff  <= left_fresh_in;
         right_fresh_ff <= right_fresh_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(left_fresh_ff && right_fresh_ff))
      else $error("Both fresh flags are set while waiting for a word.");

   assert property (@(posedge clock) disable iff (reset)
      cmd.launch |=> !cmd.launch)
      else $error("An iterative unit was launched twice in a row.");

   assert property (@(posedge clock) disable iff (reset)
      (unit_state && !launched_ff) |-> !unit_done)
      else $error("A unit reported completion before it was launched.");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("A result word appeared outside the output step.");

endmodule
`default_nettype wire

/* sv/two_anchor_position_solver.sv */
// Top level of the two-anchor position solver: controller and datapath.
// A word that completes a pair starts a solve made of three root extractions, a divide
// and two CORDIC passes, with the multiply steps sharing one multiplier; other words
// only load their range.
// Throughput: one solve at a time; input is stalled for the whole solve.
// Reset clears the fresh flags and the handshake state and loads the baseline with 0.3 m.
`default_nettype none
module two_anchor_position_solver #(
   parameter int ANGLE_FRAC_BITS = taps_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STEPS    = taps_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic        [taps_pkg::RANGE_W-1:0] req_distance,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [taps_pkg::X_W-1:0]     rsp_x_position,
   output logic        [taps_pkg::RANGE_W-1:0] rsp_y_position,
   output logic        [taps_pkg::ANG_W-1:0]   rsp_angle_at_target,
   output logic        [taps_pkg::ANG_W-1:0]   rsp_angle_at_left,
   output logic        [taps_pkg::ANG_W-1:0]   rsp_angle_at_right,
   output logic                                rsp_triangle_valid,
   output logic                                rsp_position_valid,
   input  logic                                csr_write_enable,
   input  logic        [taps_pkg::RANGE_W-1:0] csr_write_data
);
   import taps_pkg::*;

   cmd_type    cmd;
   status_type status;

   taps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   taps_datapath #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .CORDIC_STEPS    (CORDIC_STEPS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_distance        (req_distance),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_x_position      (rsp_x_position),
      .rsp_y_position      (rsp_y_position),
      .rsp_angle_at_target (rsp_angle_at_target),
      .rsp_angle_at_left   (rsp_angle_at_left),
      .rsp_angle_at_right  (rsp_angle_at_right),
      .rsp_triangle_valid  (rsp_triangle_valid),
      .rsp_position_valid  (rsp_position_valid)
   );

endmodule
`default_nettype wire
